[design/tcm_pkg.sv]
// Shared types and constants for the thermal channel monitor.
`timescale 1ns / 1ps
package tcm_pkg;

  localparam int unsigned DATA_W    = 10;
  localparam int unsigned CAL_W     = 9;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned CALC_W    = 12;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_COLD    = 3'd1,
    MODE_HOT     = 3'd2,
    MODE_MAJOR   = 3'd3,
    MODE_COUNT   = 3'd4,
    MODE_TRIPPED = 3'd5,
    MODE_FAULT   = 3'd6
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_COLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL   = 3'd6;

  localparam logic [LVL_W-1:0] LVL_NONE  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MINOR = 2'd1;
  localparam logic [LVL_W-1:0] LVL_MAJOR = 2'd2;
  localparam logic [LVL_W-1:0] LVL_TRIP  = 2'd3;

  localparam logic [DATA_W-1:0] TEMP_MAX = 10'd1023;

  typedef struct packed {
    logic [DATA_W-1:0]       cold;
    logic [DATA_W-1:0]       warm;
    logic [DATA_W-1:0]       major;
    logic [DATA_W-1:0]       trip;
    logic [DATA_W-1:0]       high;
    logic [DATA_W-1:0]       rate;
    logic signed [CAL_W-1:0] cal;
  } cfg_t;

  typedef struct packed {
    mode_e             next_mode;
    logic [DATA_W-1:0] temperature;
    logic              rate_error;
    logic [LVL_W-1:0]  alarm_level;
    logic              trip_drive;
    logic              latch_set;
    logic              unsilence;
  } result_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_WR_HEAD,
    H_WR_TAIL,
    H_READ,
    H_DRAIN,
    H_DONE
  } hist_st_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_HIST,
    C_DIV,
    C_OUT
  } ctl_st_e;

endpackage

[design/tcm_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tcm_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/tcm_hist.sv]
// Sample history in a circular RAM: two-entry insert, then a read walk for sum and rate check.
`timescale 1ns / 1ps
module tcm_hist #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [tcm_pkg::DATA_W-1:0]                 sample_i,
  input  logic [tcm_pkg::DATA_W-1:0]                 rate_limit_i,
  output logic                                       done_o,
  output logic [tcm_pkg::DATA_W+$clog2(DEPTH)-1:0]   sum_o,
  output logic                                       rate_err_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = tcm_pkg::DATA_W + AW;

  tcm_pkg::hist_st_e st_q, st_d;

  logic [AW-1:0]              base_q, ptr_q, tail_addr, waddr;
  logic [CW-1:0]              cnt_q;
  logic [DEPTH-1:0]           valid_q;
  logic                       rd_pend_q, first_q, rd_vld_q, we;
  logic [tcm_pkg::DATA_W-1:0] sample_q, prev_q, rdata, rd_val, diff;
  logic [SW-1:0]              sum_q;
  logic                       rerr_q, pair_hit;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  assign tail_addr = (base_q == '0) ? AW'(DEPTH - 1) : base_q - 1'b1;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      tcm_pkg::H_IDLE:    if (start_i) st_d = tcm_pkg::H_WR_HEAD;
      tcm_pkg::H_WR_HEAD: st_d = tcm_pkg::H_WR_TAIL;
      tcm_pkg::H_WR_TAIL: st_d = tcm_pkg::H_READ;
      tcm_pkg::H_READ:    if (cnt_q == CW'(DEPTH - 1)) st_d = tcm_pkg::H_DRAIN;
      tcm_pkg::H_DRAIN:   st_d = tcm_pkg::H_DONE;
      tcm_pkg::H_DONE:    st_d = tcm_pkg::H_IDLE;
      default:            st_d = tcm_pkg::H_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    we     = 1'b0;
    waddr  = base_q;
    done_o = 1'b0;
    unique case (st_q)
      tcm_pkg::H_WR_HEAD: we = 1'b1;
      tcm_pkg::H_WR_TAIL: begin
        we    = 1'b1;
        waddr = tail_addr;
      end
      tcm_pkg::H_DONE:    done_o = 1'b1;
      default: ;
    endcase
  end

  tcm_ram #(
    .WIDTH(tcm_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(sample_q),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // never-written entries read as zero
  assign rd_val   = rd_vld_q ? rdata : '0;
  assign diff     = (rd_val > prev_q) ? rd_val - prev_q : prev_q - rd_val;
  assign pair_hit = (diff != '0) && (diff >= rate_limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= tcm_pkg::H_IDLE;
      base_q    <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      valid_q   <= '0;
      rd_pend_q <= 1'b0;
      first_q   <= 1'b1;
    end else begin
      st_q      <= st_d;
      rd_pend_q <= (st_q == tcm_pkg::H_READ);
      if (rd_pend_q) first_q <= 1'b0;
      unique case (st_q)
        tcm_pkg::H_WR_HEAD: begin
          valid_q[base_q] <= 1'b1;
          first_q         <= 1'b1;
        end
        tcm_pkg::H_WR_TAIL: begin
          valid_q[tail_addr] <= 1'b1;
          base_q             <= wrap_inc(base_q);
          ptr_q              <= wrap_inc(base_q);
          cnt_q              <= '0;
        end
        tcm_pkg::H_READ: begin
          ptr_q <= wrap_inc(ptr_q);
          cnt_q <= cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (st_q == tcm_pkg::H_IDLE)) sample_q <= sample_i;
    rd_vld_q <= valid_q[ptr_q];
    if (st_q == tcm_pkg::H_WR_HEAD) begin
      sum_q  <= '0;
      rerr_q <= 1'b0;
    end else if (rd_pend_q) begin
      sum_q  <= sum_q + SW'(rd_val);
      prev_q <= rd_val;
      if (!first_q && pair_hit) rerr_q <= 1'b1;
    end
  end

  assign sum_o      = sum_q;
  assign rate_err_o = rerr_q;

endmodule

[design/tcm_div.sv]
// Average of the history sum by the constant depth: one registered reciprocal multiply.
`timescale 1ns / 1ps
module tcm_div #(
  parameter int unsigned DIVISOR = 8
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [tcm_pkg::DATA_W+$clog2(DIVISOR)-1:0]  dividend_i,
  output logic                                        done_o,
  output logic [tcm_pkg::DATA_W-1:0]                  quot_o
);

  localparam int unsigned SW = tcm_pkg::DATA_W + $clog2(DIVISOR);
  localparam int unsigned QW = tcm_pkg::DATA_W;
  localparam int unsigned MW = SW + 2;
  // floor(n * MULT / 2^SH) equals floor(n / DIVISOR) for every n below 2^SW
  localparam int unsigned SH = SW + $clog2(DIVISOR);
  localparam int unsigned PW = SH + QW;
  localparam longint unsigned MULT_FULL = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;
  localparam logic [MW-1:0] MULT = MW'(MULT_FULL);

  logic [PW-1:0] prod_q;
  logic          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PW'(dividend_i) * PW'(MULT);
    end
  end

  assign done_o = done_q;
  assign quot_o = prod_q[SH +: QW];

endmodule

[design/tcm_eval.sv]
// Calibration, saturation and alarm mode transition for one averaged reading.
`timescale 1ns / 1ps
module tcm_eval #(
  parameter int unsigned TRIP_TICKS = 50,
  parameter int unsigned HYSTERESIS = 10,
  parameter int unsigned RAW_MIN    = 0,
  parameter int unsigned RAW_MAX    = 1023
) (
  input  logic [tcm_pkg::DATA_W-1:0] avg_i,
  input  logic                       rate_err_i,
  input  tcm_pkg::mode_e             mode_i,
  input  logic [tcm_pkg::TICK_W-1:0] ticks_i,
  input  tcm_pkg::cfg_t              cfg_i,
  output tcm_pkg::result_t           res_o,
  output logic [tcm_pkg::TICK_W-1:0] ticks_o
);

  localparam int unsigned CW = tcm_pkg::CALC_W;

  logic signed [CW-1:0] avg_s, cal_s, t_raw, t_sel, t_s;
  logic signed [CW-1:0] lim_cold, lim_warm, lim_major, lim_trip, lim_high;
  logic signed [CW-1:0] h_cold, h_warm, h_maj, h_trip, hyst;
  logic [tcm_pkg::DATA_W-1:0] temp;
  logic [tcm_pkg::TICK_W-1:0] ticks_inc;
  logic in_range;
  tcm_pkg::mode_e next;
  logic [tcm_pkg::LVL_W-1:0] level;
  logic latch, unsil;

  assign avg_s    = $signed({2'b00, avg_i});
  assign cal_s    = $signed({{(CW - tcm_pkg::CAL_W){cfg_i.cal[tcm_pkg::CAL_W-1]}}, cfg_i.cal});
  assign in_range = (avg_i >= tcm_pkg::DATA_W'(RAW_MIN)) && (avg_i <= tcm_pkg::DATA_W'(RAW_MAX));
  assign t_raw    = avg_s + cal_s;
  assign t_sel    = in_range ? t_raw : avg_s;

  always_comb begin
    if (t_sel < 0) begin
      temp = '0;
    end else if (t_sel > $signed({2'b00, tcm_pkg::TEMP_MAX})) begin
      temp = tcm_pkg::TEMP_MAX;
    end else begin
      temp = t_sel[tcm_pkg::DATA_W-1:0];
    end
  end

  assign t_s       = $signed({2'b00, temp});
  assign hyst      = $signed(CW'(HYSTERESIS));
  assign lim_cold  = $signed({2'b00, cfg_i.cold});
  assign lim_warm  = $signed({2'b00, cfg_i.warm});
  assign lim_major = $signed({2'b00, cfg_i.major});
  assign lim_trip  = $signed({2'b00, cfg_i.trip});
  assign lim_high  = $signed({2'b00, cfg_i.high});
  assign h_cold    = lim_cold + hyst;
  assign h_warm    = lim_warm - hyst;
  assign h_maj     = lim_major - hyst;
  assign h_trip    = lim_trip - hyst;

  assign ticks_inc = (ticks_i == '1) ? ticks_i : ticks_i + 1'b1;

  always_comb begin
    next    = tcm_pkg::MODE_FAULT;
    level   = tcm_pkg::LVL_MINOR;
    latch   = 1'b0;
    unsil   = 1'b0;
    ticks_o = '0;
    unique case (mode_i)
      tcm_pkg::MODE_NORMAL: begin
        level = tcm_pkg::LVL_NONE;
        priority if (rate_err_i) begin
          next  = tcm_pkg::MODE_FAULT;
          unsil = 1'b1;
        end else if (t_s <= lim_cold) begin
          next  = tcm_pkg::MODE_COLD;
          unsil = 1'b1;
        end else if (t_s >= lim_warm) begin
          next  = tcm_pkg::MODE_HOT;
          unsil = 1'b1;
        end else begin
          next = tcm_pkg::MODE_NORMAL;
        end
      end
      tcm_pkg::MODE_COLD: begin
        priority if (rate_err_i) begin
          next  = tcm_pkg::MODE_FAULT;
          unsil = 1'b1;
        end else if (t_s > h_cold) begin
          next = tcm_pkg::MODE_NORMAL;
        end else begin
          next = tcm_pkg::MODE_COLD;
        end
      end
      tcm_pkg::MODE_HOT: begin
        priority if (rate_err_i) begin
          next  = tcm_pkg::MODE_FAULT;
          unsil = 1'b1;
        end else if (t_s < h_warm) begin
          next = tcm_pkg::MODE_NORMAL;
        end else if (t_s >= lim_major) begin
          next  = tcm_pkg::MODE_MAJOR;
          unsil = 1'b1;
        end else begin
          next = tcm_pkg::MODE_HOT;
        end
      end
      tcm_pkg::MODE_MAJOR: begin
        level = tcm_pkg::LVL_MAJOR;
        priority if (rate_err_i) begin
          next = tcm_pkg::MODE_FAULT;
        end else if (t_s < h_maj) begin
          next = tcm_pkg::MODE_HOT;
        end else if (t_s >= lim_trip) begin
          next  = tcm_pkg::MODE_COUNT;
          unsil = 1'b1;
          latch = 1'b1;
        end else begin
          next = tcm_pkg::MODE_MAJOR;
        end
      end
      tcm_pkg::MODE_COUNT: begin
        level   = tcm_pkg::LVL_TRIP;
        ticks_o = ticks_inc;
        priority if (rate_err_i || (t_s >= lim_high)) begin
          next = tcm_pkg::MODE_FAULT;
        end else if (t_s < h_trip) begin
          next = tcm_pkg::MODE_MAJOR;
        end else if (ticks_inc >= tcm_pkg::TICK_W'(TRIP_TICKS)) begin
          next  = tcm_pkg::MODE_TRIPPED;
          unsil = 1'b1;
        end else begin
          next = tcm_pkg::MODE_COUNT;
        end
      end
      tcm_pkg::MODE_TRIPPED: begin
        level = tcm_pkg::LVL_TRIP;
        priority if (rate_err_i || (t_s >= lim_high)) begin
          next = tcm_pkg::MODE_FAULT;
        end else if (t_s < h_trip) begin
          next = tcm_pkg::MODE_MAJOR;
        end else begin
          next = tcm_pkg::MODE_TRIPPED;
        end
      end
      default: begin
        // fault, and the unused code
        if (rate_err_i || (t_s >= lim_high)) begin
          next = tcm_pkg::MODE_FAULT;
        end else begin
          next = tcm_pkg::MODE_NORMAL;
        end
      end
    endcase
  end

  assign res_o.next_mode   = next;
  assign res_o.temperature = temp;
  assign res_o.rate_error  = rate_err_i;
  assign res_o.alarm_level = level;
  assign res_o.trip_drive  = (mode_i == tcm_pkg::MODE_TRIPPED);
  assign res_o.latch_set   = latch;
  assign res_o.unsilence   = unsil;

endmodule

[design/thermal_channel_monitor.sv]
// Top level of the thermal channel monitor: control, configuration and result register.
`timescale 1ns / 1ps
// One request in flight at a time. From acceptance until its result is registered, two
// RAM writes insert the new sample, HISTORY_DEPTH RAM reads walk the history for the
// sum and the adjacent-pair rate check, the H_DRAIN and H_DONE states finish the read
// pipeline, one registered reciprocal multiply forms the average and the result
// register is loaded. The next sample is accepted the cycle after that load; the load
// waits only while an earlier result is still held by out_ready_i. History starts all
// zero after reset; no clearing pass is needed. Configuration is to be written with
// cfg_we_i, cfg_idx_i and cfg_data_i only while the block is idle; the block itself
// does not enforce this. An index beyond the register list is ignored.
module thermal_channel_monitor #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned TRIP_TICKS    = 50,
  parameter int unsigned HYSTERESIS    = 10,
  parameter int unsigned RAW_MIN       = 0,
  parameter int unsigned RAW_MAX       = 1023
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcm_pkg::DATA_W-1:0]    sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    next_mode_o,
  output logic [tcm_pkg::DATA_W-1:0]    temperature_o,
  output logic                          rate_error_o,
  output logic [tcm_pkg::LVL_W-1:0]     alarm_level_o,
  output logic                          trip_drive_o,
  output logic                          latch_set_o,
  output logic                          unsilence_o,
  input  logic                          cfg_we_i,
  input  logic [tcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tcm_pkg::DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SW = tcm_pkg::DATA_W + $clog2(HISTORY_DEPTH);

  tcm_pkg::ctl_st_e st_q, st_d;
  tcm_pkg::cfg_t    cfg_q;
  tcm_pkg::mode_e   mode_q;
  tcm_pkg::result_t res, res_q;

  logic [tcm_pkg::TICK_W-1:0] ticks_q, ticks_n;
  logic [SW-1:0]              sum;
  logic [tcm_pkg::DATA_W-1:0] avg;
  logic hist_start, hist_done, rate_err, div_done, out_valid_q, load_ok, load;

  assign load_ok    = !out_valid_q || out_ready_i;
  assign hist_start = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      tcm_pkg::C_IDLE: if (in_valid_i) st_d = tcm_pkg::C_HIST;
      tcm_pkg::C_HIST: if (hist_done) st_d = tcm_pkg::C_DIV;
      tcm_pkg::C_DIV:  if (div_done) st_d = tcm_pkg::C_OUT;
      tcm_pkg::C_OUT:  if (load_ok) st_d = tcm_pkg::C_IDLE;
      default:         st_d = tcm_pkg::C_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    load       = 1'b0;
    unique case (st_q)
      tcm_pkg::C_IDLE: in_ready_o = 1'b1;
      tcm_pkg::C_OUT:  load = load_ok;
      default: ;
    endcase
  end

  tcm_hist #(
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (hist_start),
    .sample_i    (sample_i),
    .rate_limit_i(cfg_q.rate),
    .done_o      (hist_done),
    .sum_o       (sum),
    .rate_err_o  (rate_err)
  );

  tcm_div #(
    .DIVISOR(HISTORY_DEPTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (hist_done),
    .dividend_i(sum),
    .done_o    (div_done),
    .quot_o    (avg)
  );

  tcm_eval #(
    .TRIP_TICKS(TRIP_TICKS),
    .HYSTERESIS(HYSTERESIS),
    .RAW_MIN   (RAW_MIN),
    .RAW_MAX   (RAW_MAX)
  ) u_eval (
    .avg_i     (avg),
    .rate_err_i(rate_err),
    .mode_i    (mode_q),
    .ticks_i   (ticks_q),
    .cfg_i     (cfg_q),
    .res_o     (res),
    .ticks_o   (ticks_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= tcm_pkg::C_IDLE;
      mode_q      <= tcm_pkg::MODE_NORMAL;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
      cfg_q.cold  <= 10'd100;
      cfg_q.warm  <= 10'd600;
      cfg_q.major <= 10'd700;
      cfg_q.trip  <= 10'd800;
      cfg_q.high  <= 10'd1000;
      cfg_q.rate  <= 10'd50;
      cfg_q.cal   <= '0;
    end else begin
      st_q <= st_d;
      if (load) begin
        out_valid_q <= 1'b1;
        mode_q      <= res.next_mode;
        ticks_q     <= ticks_n;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tcm_pkg::CFG_COLD:  cfg_q.cold  <= cfg_data_i;
          tcm_pkg::CFG_WARM:  cfg_q.warm  <= cfg_data_i;
          tcm_pkg::CFG_MAJOR: cfg_q.major <= cfg_data_i;
          tcm_pkg::CFG_TRIP:  cfg_q.trip  <= cfg_data_i;
          tcm_pkg::CFG_HIGH:  cfg_q.high  <= cfg_data_i;
          tcm_pkg::CFG_RATE:  cfg_q.rate  <= cfg_data_i;
          tcm_pkg::CFG_CAL:   cfg_q.cal   <= $signed(cfg_data_i[tcm_pkg::CAL_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign next_mode_o   = res_q.next_mode;
  assign temperature_o = res_q.temperature;
  assign rate_error_o  = res_q.rate_error;
  assign alarm_level_o = res_q.alarm_level;
  assign trip_drive_o  = res_q.trip_drive;
  assign latch_set_o   = res_q.latch_set;
  assign unsilence_o   = res_q.unsilence;

endmodule

[bench/thermal_channel_monitor_tb.sv]
// Self-checking testbench for the thermal channel monitor: directed table, then random sample walks.
`timescale 1ns / 1ps
module thermal_channel_monitor_tb;
  import tcm_pkg::*;

  localparam int DEPTH        = 8;
  localparam int TRIP_TICKS   = 50;
  localparam int HYSTERESIS   = 10;
  localparam int RAW_MIN      = 0;
  localparam int RAW_MAX      = 1023;
  localparam int RANDOM_ITEMS = 1700;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTED = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [DATA_W-1:0]    sample_i    = '0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [2:0]           next_mode_o;
  logic [DATA_W-1:0]    temperature_o;
  logic                 rate_error_o;
  logic [LVL_W-1:0]     alarm_level_o;
  logic                 trip_drive_o;
  logic                 latch_set_o;
  logic                 unsilence_o;

  // Predictor state
  logic [DATA_W-1:0] window [DEPTH] = '{default: '0};
  mode_e             mode_now        = MODE_NORMAL;
  logic [7:0]        countdown_ticks = '0;
  cfg_t              limits = '{10'd100, 10'd600, 10'd700, 10'd800, 10'd1000, 10'd50, 9'sd0};

  result_t pending_reports [$];
  int      mismatch_count = 0;
  bit      calm = 1'b0;
  int      stall_left = 0;

  typedef struct {
    logic [DATA_W-1:0] sample;
    bit                typed;
    result_t           want;
  } step_row_t;

  // Typed rows: after reset, full-scale samples, fault entry; the rest use the predictor.
  step_row_t directed [21] = '{
    '{10'd0,    1'b1, '{MODE_COLD,  10'd0,    1'b0, LVL_NONE,  1'b0, 1'b0, 1'b1}},
    '{10'd1023, 1'b1, '{MODE_FAULT, 10'd255,  1'b1, LVL_MINOR, 1'b0, 1'b0, 1'b1}},
    '{10'd1023, 1'b1, '{MODE_FAULT, 10'd383,  1'b1, LVL_MINOR, 1'b0, 1'b0, 1'b0}},
    '{10'd1023, 1'b0, '0},
    '{10'd1023, 1'b0, '0},
    '{10'd1023, 1'b0, '0},
    '{10'd1023, 1'b0, '0},
    '{10'd1023, 1'b1, '{MODE_FAULT, 10'd1023, 1'b0, LVL_MINOR, 1'b0, 1'b0, 1'b0}},
    '{10'd974,  1'b0, '0},
    '{10'd925,  1'b0, '0},
    '{10'd876,  1'b0, '0},
    '{10'd827,  1'b0, '0},
    '{10'd778,  1'b0, '0},
    '{10'd729,  1'b0, '0},
    '{10'd680,  1'b0, '0},
    '{10'd631,  1'b0, '0},
    '{10'd581,  1'b0, '0},
    '{10'd341,  1'b0, '0},
    '{10'd682,  1'b0, '0},
    '{10'd682,  1'b0, '0},
    '{10'd682,  1'b0, '0}
  };

  thermal_channel_monitor #(
    .HISTORY_DEPTH(DEPTH),
    .TRIP_TICKS   (TRIP_TICKS),
    .HYSTERESIS   (HYSTERESIS),
    .RAW_MIN      (RAW_MIN),
    .RAW_MAX      (RAW_MAX)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .next_mode_o  (next_mode_o),
    .temperature_o(temperature_o),
    .rate_error_o (rate_error_o),
    .alarm_level_o(alarm_level_o),
    .trip_drive_o (trip_drive_o),
    .latch_set_o  (latch_set_o),
    .unsilence_o  (unsilence_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [DATA_W-1:0] clamp_code(input int v);
    if (v < 0) return '0;
    if (v > 1023) return 10'd1023;
    return v[DATA_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advances the channel by one sample and returns the status report it produces.
  function automatic result_t evaluate_tick(input logic [DATA_W-1:0] s);
    result_t r;
    int      i, sum, temp, diff, rate;
    int      cold, warm, major, trip, high;
    logic    rerr;
    mode_e   nxt;
    window[DEPTH-1] = s;
    for (i = 0; i < DEPTH - 1; i++) window[i] = window[i+1];
    sum = 0;
    for (i = 0; i < DEPTH; i++) sum += window[i];
    temp = sum / DEPTH;
    if (temp >= RAW_MIN && temp <= RAW_MAX) temp += $signed(limits.cal);
    if (temp < 0) temp = 0;
    if (temp > 1023) temp = 1023;
    rate = limits.rate;
    rerr = 1'b0;
    for (i = 0; i < DEPTH - 1; i++) begin
      diff = (window[i] > window[i+1]) ? window[i] - window[i+1] : window[i+1] - window[i];
      if (diff != 0 && diff >= rate) rerr = 1'b1;
    end
    cold  = limits.cold;
    warm  = limits.warm;
    major = limits.major;
    trip  = limits.trip;
    high  = limits.high;
    r = '0;
    r.trip_drive = (mode_now == MODE_TRIPPED);
    case (mode_now)
      MODE_NORMAL: begin
        r.alarm_level = LVL_NONE;
        countdown_ticks = '0;
        if (rerr) begin
          nxt = MODE_FAULT;
          r.unsilence = 1'b1;
        end else if (temp <= cold) begin
          nxt = MODE_COLD;
          r.unsilence = 1'b1;
        end else if (temp >= warm) begin
          nxt = MODE_HOT;
          r.unsilence = 1'b1;
        end else nxt = MODE_NORMAL;
      end
      MODE_COLD: begin
        r.alarm_level = LVL_MINOR;
        countdown_ticks = '0;
        if (rerr) begin
          nxt = MODE_FAULT;
          r.unsilence = 1'b1;
        end else if (temp > cold + HYSTERESIS) nxt = MODE_NORMAL;
        else nxt = MODE_COLD;
      end
      MODE_HOT: begin
        r.alarm_level = LVL_MINOR;
        countdown_ticks = '0;
        if (rerr) begin
          nxt = MODE_FAULT;
          r.unsilence = 1'b1;
        end else if (temp < warm - HYSTERESIS) nxt = MODE_NORMAL;
        else if (temp >= major) begin
          nxt = MODE_MAJOR;
          r.unsilence = 1'b1;
        end else nxt = MODE_HOT;
      end
      MODE_MAJOR: begin
        r.alarm_level = LVL_MAJOR;
        countdown_ticks = '0;
        if (rerr) nxt = MODE_FAULT;
        else if (temp < major - HYSTERESIS) nxt = MODE_HOT;
        else if (temp >= trip) begin
          nxt = MODE_COUNT;
          r.unsilence = 1'b1;
          r.latch_set = 1'b1;
        end else nxt = MODE_MAJOR;
      end
      MODE_COUNT: begin
        r.alarm_level = LVL_TRIP;
        if (countdown_ticks < 8'd255) countdown_ticks++;
        if (rerr) nxt = MODE_FAULT;
        else if (temp >= high) nxt = MODE_FAULT;
        else if (temp < trip - HYSTERESIS) nxt = MODE_MAJOR;
        else if (countdown_ticks >= TRIP_TICKS) begin
          nxt = MODE_TRIPPED;
          r.unsilence = 1'b1;
        end else nxt = MODE_COUNT;
      end
      MODE_TRIPPED: begin
        r.alarm_level = LVL_TRIP;
        countdown_ticks = '0;
        if (rerr) nxt = MODE_FAULT;
        else if (temp >= high) nxt = MODE_FAULT;
        else if (temp < trip - HYSTERESIS) nxt = MODE_MAJOR;
        else nxt = MODE_TRIPPED;
      end
      default: begin
        r.alarm_level = LVL_MINOR;
        countdown_ticks = '0;
        if (rerr || temp >= high) nxt = MODE_FAULT;
        else nxt = MODE_NORMAL;
      end
    endcase
    r.next_mode   = nxt;
    r.temperature = temp[DATA_W-1:0];
    r.rate_error  = rerr;
    mode_now = nxt;
    return r;
  endfunction

  function automatic bit note_error();
    mismatch_count++;
    return mismatch_count <= MAX_REPORTED;
  endfunction

  task automatic check_report(input result_t got);
    result_t want;
    if (pending_reports.size() == 0) begin
      if (note_error()) $display("%0t: report with no request outstanding", $time);
    end else begin
      want = pending_reports.pop_front();
      if (got !== want && note_error()) begin
        $display("%0t: mismatch (mode/temp/rate/level/trip/latch/unsilence)", $time);
        $display("  expected %0d/%0d/%0b/%0d/%0b/%0b/%0b", want.next_mode, want.temperature,
                 want.rate_error, want.alarm_level, want.trip_drive, want.latch_set,
                 want.unsilence);
        $display("  got      %0d/%0d/%0b/%0d/%0b/%0b/%0b", got.next_mode, got.temperature,
                 got.rate_error, got.alarm_level, got.trip_drive, got.latch_set,
                 got.unsilence);
      end
    end
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] s, input bit typed, input result_t want);
    int      gap;
    result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = evaluate_tick(s);
    pending_reports.push_back(typed ? want : pred);
  endtask

  // Hold off requests until every outstanding report has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_COLD:  limits.cold  = data;
      CFG_WARM:  limits.warm  = data;
      CFG_MAJOR: limits.major = data;
      CFG_TRIP:  limits.trip  = data;
      CFG_HIGH:  limits.high  = data;
      CFG_RATE:  limits.rate  = data;
      CFG_CAL:   limits.cal   = data[CAL_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_report(result_t'{mode_e'(next_mode_o), temperature_o, rate_error_o, alarm_level_o,
                             trip_drive_o, latch_set_o, unsilence_o});
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left  <= pick_gap();
    end
  end

  initial begin
    int                phase, n, len, random_sent;
    int                cur, target, hold, stepmax, step, thr, c_off;
    bit                noisy;
    cfg_t              nxt_cfg;
    logic [DATA_W-1:0] s;
    random_sent = 0;
    phase       = 0;
    cur         = 682;
    target      = cur;
    hold        = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_sample(directed[k].sample, directed[k].typed, directed[k].want);

    while (random_sent < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0: nxt_cfg = '{10'd100, 10'd600, 10'd700, 10'd800, 10'd1000, 10'd0, 9'sd0};
        1: nxt_cfg = '{10'd1023, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, -9'sd255};
        2: nxt_cfg = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1, 9'sd255};
        3: nxt_cfg = '{10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 9'sd0};
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            nxt_cfg.cold  = clamp_code(int'($urandom_range(0, 1023)));
            nxt_cfg.warm  = clamp_code(int'($urandom_range(0, 1023)));
            nxt_cfg.major = clamp_code(int'($urandom_range(0, 1023)));
            nxt_cfg.trip  = clamp_code(int'($urandom_range(0, 1023)));
            nxt_cfg.high  = clamp_code(int'($urandom_range(0, 1023)));
          end else begin
            thr = $urandom_range(0, 300);
            nxt_cfg.cold  = clamp_code(thr);
            thr += $urandom_range(0, 300);
            nxt_cfg.warm  = clamp_code(thr);
            thr += $urandom_range(0, 150);
            nxt_cfg.major = clamp_code(thr);
            thr += $urandom_range(0, 150);
            nxt_cfg.trip  = clamp_code(thr);
            thr += $urandom_range(0, 250);
            nxt_cfg.high  = clamp_code(thr);
          end
          if ($urandom_range(0, 7) == 0) nxt_cfg.rate = clamp_code(int'($urandom_range(0, 1023)));
          else nxt_cfg.rate = clamp_code(int'($urandom_range(20, 400)));
          c_off = int'($urandom_range(0, 510)) - 255;
          nxt_cfg.cal = c_off[CAL_W-1:0];
        end
      endcase
      write_register(CFG_COLD, nxt_cfg.cold);
      write_register(CFG_WARM, nxt_cfg.warm);
      write_register(CFG_MAJOR, nxt_cfg.major);
      write_register(CFG_TRIP, nxt_cfg.trip);
      write_register(CFG_HIGH, nxt_cfg.high);
      write_register(CFG_RATE, nxt_cfg.rate);
      write_register(CFG_CAL, {$urandom_range(0, 1) == 1, nxt_cfg.cal});
      // unused index, must leave every limit alone
      write_register(CFG_SPARE, clamp_code(int'($urandom_range(0, 1023))));
      cfg_we_i <= 1'b0;

      calm  = ($urandom_range(0, 3) == 0);
      noisy = ($urandom_range(0, 5) == 0);
      thr   = limits.rate;
      stepmax = (thr > 41) ? 40 : ((thr > 1) ? thr - 1 : 0);
      target = cur;
      hold   = 0;
      len    = $urandom_range(40, 160);
      for (n = 0; n < len; n++) begin
        if (noisy) begin
          cur = $urandom_range(0, 1023);
        end else begin
          if (cur == target) begin
            if (hold > 0) hold--;
            else begin
              c_off = $signed(limits.cal);
              case ($urandom_range(0, 5))
                0: thr = limits.cold;
                1: thr = limits.warm;
                2: thr = limits.major;
                3: thr = limits.trip;
                4: thr = limits.high;
                default: thr = int'($urandom_range(0, 1023)) + c_off;
              endcase
              target = clamp_code(thr - c_off + int'($urandom_range(0, 40)) - 20);
              hold   = $urandom_range(0, 120);
            end
          end
          if (stepmax == 0) target = cur;
          else if (cur != target) begin
            step = $urandom_range(1, stepmax);
            if (cur < target) cur = (target - cur < step) ? target : cur + step;
            else cur = (cur - target < step) ? target : cur - step;
          end
          // occasional jump breaks the walk
          if ($urandom_range(0, 39) == 0) cur = $urandom_range(0, 1023);
        end
        s = cur[DATA_W-1:0];
        send_sample(s, 1'b0, '0);
        random_sent++;
        if ($urandom_range(0, 199) == 0) settle();
      end
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d reports still outstanding", pending_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[thermal_channel_monitor.f]
design/tcm_pkg.sv
design/tcm_ram.sv
design/tcm_hist.sv
design/tcm_div.sv
design/tcm_eval.sv
design/thermal_channel_monitor.sv
bench/thermal_channel_monitor_tb.sv
